[design/spq_pkg.sv]
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by spq_ctrl, spq_dp and the top level.
`default_nettype none
package spq_pkg;

  localparam int CAPACITY = 64;
  localparam int ID_W     = 16;
  localparam int KEY_W    = 32;
  localparam int CMD_W    = 3;
  localparam int STAT_W   = 2;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FIND   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture the command and register the cell compares
    logic apply;  // update the cells and load the result register
  } spq_cmd_t;

endpackage
`default_nettype wire

[design/sorted_priority_queue_by_id_top.sv]
// Top level of the sorted priority queue: controller plus cell datapath.
// Depends on spq_pkg, spq_ctrl and spq_dp.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------------
//   in_     | in        | in_valid / in_stall | in_command, in_item_id, in_item_key
//   out_    | out       | out_valid/out_stall | out_status, out_id, out_key,
//           |           |                     | out_occupancy
//
// Each command runs as follows: the transfer edge registers the key and id
// compares of all cells in parallel, the next edge shifts the cells and loads
// the result register. One command is in flight at a time.
// A new transfer is taken while the previous result is being taken.
// Reset (rst_n low, synchronous) empties the queue; cell contents are left as they are.
// While out_stall holds a result, in_stall stays high; no new transfer is taken
// until that result leaves.
`default_nettype none
module sorted_priority_queue_by_id_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [spq_pkg::CMD_W-1:0]  in_command,
  input  wire logic [spq_pkg::ID_W-1:0]   in_item_id,
  input  wire logic [spq_pkg::KEY_W-1:0]  in_item_key,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [spq_pkg::STAT_W-1:0]      out_status,
  output logic [spq_pkg::ID_W-1:0]        out_id,
  output logic [spq_pkg::KEY_W-1:0]       out_key,
  output logic [spq_pkg::CNT_W-1:0]       out_occupancy
);
  import spq_pkg::*;

  spq_cmd_t dp_cmd;

  // sequence load and apply, own both handshakes
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_cmd    (dp_cmd)
  );

  // hold the sorted cells and the result register
  spq_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .dp_cmd        (dp_cmd),
    .in_command    (in_command),
    .in_item_id    (in_item_id),
    .in_item_key   (in_item_key),
    .out_status    (out_status),
    .out_id        (out_id),
    .out_key       (out_key),
    .out_occupancy (out_occupancy)
  );

endmodule
`default_nettype wire

[design/spq_ctrl.sv]
// Controller for the sorted priority queue: sequencing and handshakes.
// Depends on spq_pkg.
`default_nettype none
module spq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output spq_pkg::spq_cmd_t    dp_cmd
);
  import spq_pkg::*;

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_APPLY = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;

  // accept only when the result register will be free by the apply cycle
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_APPLY;
      S_APPLY: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = (state_r == S_APPLY) ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign dp_cmd.load  = accept;
  assign dp_cmd.apply = (state_r == S_APPLY);

  a_accept_then_apply: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_APPLY))
    else $error("accepted command not applied next cycle");

  a_apply_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY) |=> out_valid_r)
    else $error("apply did not present a result");

  a_apply_needs_free_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY) |-> (!out_valid_r || !out_stall))
    else $error("result register still occupied at apply");

endmodule
`default_nettype wire

[design/spq_dp.sv]
// Datapath for the sorted priority queue: row of sorted cells, compare masks,
// entry count and result register. Depends on spq_pkg.
`default_nettype none
module spq_dp (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire spq_pkg::spq_cmd_t          dp_cmd,
  input  wire logic [spq_pkg::CMD_W-1:0]  in_command,
  input  wire logic [spq_pkg::ID_W-1:0]   in_item_id,
  input  wire logic [spq_pkg::KEY_W-1:0]  in_item_key,
  output logic [spq_pkg::STAT_W-1:0]      out_status,
  output logic [spq_pkg::ID_W-1:0]        out_id,
  output logic [spq_pkg::KEY_W-1:0]       out_key,
  output logic [spq_pkg::CNT_W-1:0]       out_occupancy
);
  import spq_pkg::*;

  // cells, ascending key order in slots below count_r
  logic [KEY_W-1:0]  cell_key_r [CAPACITY];
  logic [ID_W-1:0]   cell_id_r  [CAPACITY];
  logic [KEY_W-1:0]  cell_key_nxt [CAPACITY];
  logic [ID_W-1:0]   cell_id_nxt  [CAPACITY];
  logic [CNT_W-1:0]  count_r, count_nxt;

  // captured command and registered compares
  logic [CMD_W-1:0]  cmd_r;
  logic [ID_W-1:0]   id_r;
  logic [KEY_W-1:0]  key_r;
  logic [CAPACITY-1:0] gt_r, gt_nxt;
  logic [CAPACITY-1:0] match_r, match_nxt;

  logic [STAT_W-1:0] status_r, status_nxt;
  logic [ID_W-1:0]   res_id_r, res_id_nxt;
  logic [KEY_W-1:0]  res_key_r, res_key_nxt;
  logic [CNT_W-1:0]  occ_r;

  logic [CAPACITY-1:0] neg_match, first_oh, from_first;
  logic is_full, is_empty, has_match;

  // per-cell compares against the incoming item
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      gt_nxt[i]    = (CNT_W'(i) < count_r) && (cell_key_r[i] > in_item_key);
      match_nxt[i] = (CNT_W'(i) < count_r) && (cell_id_r[i] == in_item_id);
    end
  end

  // lowest matching slot and every slot from it upwards
  assign neg_match  = ~match_r + CAPACITY'(1);
  assign first_oh   = match_r & neg_match;
  assign from_first = match_r | neg_match;

  assign is_full   = (count_r == CNT_W'(CAPACITY));
  assign is_empty  = (count_r == '0);
  assign has_match = |match_r;

  // cell update and result
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_key_nxt[i] = cell_key_r[i];
      cell_id_nxt[i]  = cell_id_r[i];
    end
    count_nxt   = count_r;
    status_nxt  = ST_OK;
    res_id_nxt  = '0;
    res_key_nxt = '0;
    case (cmd_r)
      CMD_INSERT: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
          for (int i = 0; i < CAPACITY; i++) begin
            if (i > 0 && gt_r[(i > 0) ? i - 1 : 0]) begin
              cell_key_nxt[i] = cell_key_r[(i > 0) ? i - 1 : 0];
              cell_id_nxt[i]  = cell_id_r[(i > 0) ? i - 1 : 0];
            end else if (gt_r[i] || (count_r == CNT_W'(i))) begin
              cell_key_nxt[i] = key_r;
              cell_id_nxt[i]  = id_r;
            end
          end
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          res_id_nxt  = cell_id_r[0];
          res_key_nxt = cell_key_r[0];
          if (cmd_r == CMD_POP) begin
            count_nxt = count_r - CNT_W'(1);
            for (int i = 0; i < CAPACITY - 1; i++) begin
              cell_key_nxt[i] = cell_key_r[i + 1];
              cell_id_nxt[i]  = cell_id_r[i + 1];
            end
          end
        end
      end
      CMD_FIND, CMD_REMOVE: begin
        if (!has_match) begin
          status_nxt = ST_NOT_FOUND;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            res_id_nxt  = res_id_nxt  | (cell_id_r[i]  & {ID_W{first_oh[i]}});
            res_key_nxt = res_key_nxt | (cell_key_r[i] & {KEY_W{first_oh[i]}});
          end
          if (cmd_r == CMD_REMOVE) begin
            count_nxt = count_r - CNT_W'(1);
            for (int i = 0; i < CAPACITY - 1; i++) begin
              if (from_first[i]) begin
                cell_key_nxt[i] = cell_key_r[i + 1];
                cell_id_nxt[i]  = cell_id_r[i + 1];
              end
            end
          end
        end
      end
      CMD_CLEAR: count_nxt = '0;
      default: ;
    endcase
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_r   <= in_command;
      id_r    <= in_item_id;
      key_r   <= in_item_key;
      gt_r    <= gt_nxt;
      match_r <= match_nxt;
    end
    if (dp_cmd.apply) begin
      for (int i = 0; i < CAPACITY; i++) begin
        cell_key_r[i] <= cell_key_nxt[i];
        cell_id_r[i]  <= cell_id_nxt[i];
      end
      status_r  <= status_nxt;
      res_id_r  <= res_id_nxt;
      res_key_r <= res_key_nxt;
      occ_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (dp_cmd.apply) begin
      count_r <= count_nxt;
    end
  end

  assign out_status    = status_r;
  assign out_id        = res_id_r;
  assign out_key       = res_key_r;
  assign out_occupancy = occ_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_first_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.apply |-> $onehot0(first_oh))
    else $error("more than one first match");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.apply && cmd_r == CMD_CLEAR) |=> (count_r == '0))
    else $error("clear left entries");

  a_masks_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    $past(dp_cmd.load) |-> ($countones(match_r | gt_r) <= int'(count_r)))
    else $error("compare mask marks slot beyond count");

endmodule
`default_nettype wire
